// ----- rtl/sign_magnitude_word_alu_top_assert.svh -----
// Assertion macros for the sign-magnitude word ALU top level.
`ifndef SIGN_MAGNITUDE_WORD_ALU_TOP_ASSERT_SVH
`define SIGN_MAGNITUDE_WORD_ALU_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SMWA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smwa assertion failed");

// Implication whose consequent starts in the cycle after the antecedent.
`define SMWA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smwa assertion failed");

`endif

// ----- rtl/smwa_pkg.sv -----
// Types and constants of the sign-magnitude word ALU.
package smwa_pkg;

	localparam int WORD_W     = 15;
	localparam int VAL_W      = 14;
	localparam int MAG_W      = 13;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int DIV_STAGES = MAG_W;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [VAL_W-1:0] NEG_ZERO = 14'h2000;

	typedef struct packed {
		logic [1:0]        operation;
		logic [WORD_W-1:0] left_word;
		logic [WORD_W-1:0] right_word;
	} smwa_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic              overflow;
		logic              divide_by_zero;
	} smwa_rsp_t;

	// Item state carried down the divider chain.
	typedef struct packed {
		logic              is_div;
		logic              sign;
		logic              dz;
		logic [MAG_W-1:0]  divisor;
		logic [MAG_W-1:0]  rem;
		logic [MAG_W-1:0]  dq;
		logic [VAL_W-1:0]  alt_val;
		logic              alt_ovf;
	} smwa_stage_t;

endpackage

// ----- rtl/smwa_front.sv -----
// First pipeline stage: add, subtract and multiply, and divider setup.
module smwa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_in,
	input  smwa_pkg::smwa_req_t req,
	output logic                valid_s1,
	output smwa_pkg::smwa_stage_t stg_s1
);
	import smwa_pkg::*;

	logic [VAL_W-1:0]  a, b;
	logic              sa, sb;
	logic [MAG_W-1:0]  ma, mb;
	logic [VAL_W-1:0]  ta, tb, sum, neg_sum, sm_sum;
	logic [PROD_W-1:0] prod;
	logic              ovf;
	logic [VAL_W-1:0]  val;
	smwa_stage_t       nxt;

	assign a  = req.left_word[VAL_W-1:0];
	assign b  = req.right_word[VAL_W-1:0];
	assign sa = a[VAL_W-1];
	assign sb = b[VAL_W-1];
	assign ma = a[MAG_W-1:0];
	assign mb = b[MAG_W-1:0];

	assign ta = sa ? (VAL_W'(0) - {1'b0, ma}) : {1'b0, ma};
	assign tb = sb ? (VAL_W'(0) - {1'b0, mb}) : {1'b0, mb};
	assign sum = (req.operation == OP_SUB) ? (ta - tb) : (ta + tb);
	assign neg_sum = VAL_W'(0) - sum;
	assign sm_sum = sum[VAL_W-1] ? {1'b1, neg_sum[MAG_W-1:0]} : sum;
	assign prod = PROD_W'(ma) * PROD_W'(mb);

	always_comb begin
		unique case (req.operation)
			OP_ADD: begin
				ovf = (sa == sb) && (sa != sum[VAL_W-1]);
				val = sm_sum;
			end
			OP_SUB: begin
				ovf = (sa != sb) && (sa != sum[VAL_W-1]);
				val = sm_sum;
			end
			OP_MUL: begin
				ovf = |prod[PROD_W-1:MAG_W];
				val = {prod[MAG_W] | (sa ^ sb), prod[MAG_W-1:0]};
			end
			default: begin
				ovf = 1'b0;
				val = '0;
			end
		endcase
	end

	always_comb begin
		nxt.is_div  = (req.operation == OP_DIV);
		nxt.sign    = sa ^ sb;
		nxt.dz      = (mb == '0);
		nxt.divisor = mb;
		nxt.rem     = '0;
		nxt.dq      = ma;
		nxt.alt_val = val;
		nxt.alt_ovf = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		stg_s1 <= nxt;
	end

endmodule

// ----- rtl/smwa_div_step.sv -----
// One restoring division step: produces one quotient bit per stage.
module smwa_div_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_in,
	input  smwa_pkg::smwa_stage_t stg_in,
	output logic                  valid_out,
	output smwa_pkg::smwa_stage_t stg_out
);
	import smwa_pkg::*;

	logic [MAG_W:0]   trial;
	logic             ge;
	logic [MAG_W:0]   diff;
	smwa_stage_t      nxt;

	// The dividend shifts out of dq from the top while quotient bits enter at the bottom.
	assign trial = {stg_in.rem, stg_in.dq[MAG_W-1]};
	assign ge    = trial >= {1'b0, stg_in.divisor};
	assign diff  = trial - {1'b0, stg_in.divisor};

	always_comb begin
		nxt     = stg_in;
		nxt.rem = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
		nxt.dq  = {stg_in.dq[MAG_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		stg_out <= nxt;
	end

endmodule

// ----- rtl/sign_magnitude_word_alu_top.sv -----
// Top level of the sign-magnitude word ALU: front stage, divider chain, output stage.
//
//   channel   handshake        payload   direction
//   request   start / busy     req       in
//   result    done             rsp       out
//
// An accepted item passes through these registers in order before done rises with its result:
// one front stage, thirteen divider steps (one quotient bit each) and one output register.
// A new item is taken in every cycle; busy is held low since nothing can stall.
// Reset clears the valid bits of all stages; data registers are not reset.
// Results appear for one cycle with done high, in the order the items were taken.
module sign_magnitude_word_alu_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  smwa_pkg::smwa_req_t req,
	output logic                done,
	output smwa_pkg::smwa_rsp_t rsp
);
	import smwa_pkg::*;

	`include "sign_magnitude_word_alu_top_assert.svh"

	localparam int LATENCY = DIV_STAGES + 2;

	logic        vld [0:DIV_STAGES];
	smwa_stage_t stg [0:DIV_STAGES];
	logic        done_q;
	smwa_rsp_t   rsp_q;
	smwa_stage_t last;
	logic [VAL_W-1:0] fin_val;
	logic [VAL_W-1:0] out_val;
	smwa_rsp_t   rsp_d;

	assign busy = 1'b0;

	smwa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (start & ~busy),
		.req      (req),
		.valid_s1 (vld[0]),
		.stg_s1   (stg[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		smwa_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vld[i]),
			.stg_in    (stg[i]),
			.valid_out (vld[i+1]),
			.stg_out   (stg[i+1])
		);
	end

	assign last = stg[DIV_STAGES];

	always_comb begin
		if (!last.is_div) begin
			fin_val = last.alt_val;
		end else if (last.dz) begin
			fin_val = '0;
		end else begin
			fin_val = {last.sign, last.dq};
		end
		// Negative zero is returned as zero.
		out_val = (fin_val == NEG_ZERO) ? '0 : fin_val;
		rsp_d.result_word    = {1'b1, out_val};
		rsp_d.overflow       = last.is_div ? 1'b0 : last.alt_ovf;
		rsp_d.divide_by_zero = last.is_div & last.dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SMWA_ASSERT_NOW(a_marker_set, done, rsp.result_word[WORD_W-1])
	`SMWA_ASSERT_NOW(a_flags_exclusive, done, !(rsp.overflow && rsp.divide_by_zero))
	`SMWA_ASSERT_NOW(a_dz_gives_zero, done && rsp.divide_by_zero, rsp.result_word[VAL_W-1:0] == '0)
	`SMWA_ASSERT_NOW(a_no_neg_zero, done, rsp.result_word[VAL_W-1:0] != NEG_ZERO)
	`SMWA_ASSERT_NEXT(a_latency, vld[0], ##(LATENCY-2) done)

endmodule
